FILE: src/assert_macros.svh
// assertion helpers used by the checker in uer_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge while out of reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

// property checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

FILE: src/uer_pkg.sv
package uer_pkg;

    // field widths
    localparam int WIDTH_W  = 16;
    localparam int MM_W     = 14;
    localparam int CM_W     = 11;
    localparam int CNT_W    = 16;
    localparam int REM_W    = 11;
    localparam int CMREM_W  = 4;
    localparam int CFG_W    = 16;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 4;

    // trigger timing defaults
    localparam int TRIG_LOW_TICKS_DEF  = 2;
    localparam int TRIG_HIGH_TICKS_DEF = 10;

    // register defaults, also used when a register holds zero
    localparam logic [CFG_W-1:0] TIMEOUT_DEF   = 16'd30000;
    localparam logic [CFG_W-1:0] MIN_WIDTH_DEF = 16'd100;
    localparam logic [CFG_W-1:0] MAX_WIDTH_DEF = 16'd25000;

    // distance arithmetic: mm = (width*SOUND_NUM + ROUND_OFS) / SOUND_DEN
    localparam logic [REM_W:0]   SOUND_NUM = 12'd343;
    localparam logic [REM_W:0]   SOUND_DEN = 12'd2000;
    localparam logic [REM_W-1:0] ROUND_OFS = 11'd1000;
    localparam logic [CMREM_W-1:0] CM_DIV_LAST = 4'd9;

    // register indexes
    localparam logic [1:0] REG_TIMEOUT   = 2'd0;
    localparam logic [1:0] REG_MIN_WIDTH = 2'd1;
    localparam logic [1:0] REG_MAX_WIDTH = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_TRIG_LOW  = 3'd1,
        PH_TRIG_HIGH = 3'd2,
        PH_WAIT_RISE = 3'd3,
        PH_MEASURE   = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_RISE   = 3'd1,
        ST_NO_FALL   = 3'd2,
        ST_TOO_SHORT = 3'd3,
        ST_TOO_LONG  = 3'd4
    } t_status;

    // effective limits after default substitution
    typedef struct packed {
        logic [CFG_W-1:0] timeout;
        logic [CFG_W-1:0] min_width;
        logic [CFG_W-1:0] max_width;
    } t_cfg;

    // one result item
    typedef struct packed {
        logic               trig_level;
        logic               busy_res;
        logic               done_res;
        logic [2:0]         status;
        logic [WIDTH_W-1:0] echo_width;
        logic [MM_W-1:0]    dist_mm;
        logic [CM_W-1:0]    distance_cm;
        logic               result_valid;
    } t_result;

endpackage

FILE: src/uer_cfg_regs.sv
module uer_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [uer_pkg::ADDR_W-1:0] paddr,
    input  logic [uer_pkg::DATA_W-1:0] pwdata,
    output logic [uer_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output uer_pkg::t_cfg              o_cfg
);

    logic [uer_pkg::CFG_W-1:0] r_timeout;
    logic [uer_pkg::CFG_W-1:0] r_min_width;
    logic [uer_pkg::CFG_W-1:0] r_max_width;
    logic [1:0]                w_index;
    logic                      w_write;

    assign pready  = 1'b1;
    assign w_index = paddr[3:2];
    assign w_write = psel && penable && pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= uer_pkg::TIMEOUT_DEF;
            r_min_width <= uer_pkg::MIN_WIDTH_DEF;
            r_max_width <= uer_pkg::MAX_WIDTH_DEF;
        end else if (w_write) begin
            unique case (w_index)
                uer_pkg::REG_TIMEOUT:   r_timeout   <= pwdata[uer_pkg::CFG_W-1:0];
                uer_pkg::REG_MIN_WIDTH: r_min_width <= pwdata[uer_pkg::CFG_W-1:0];
                uer_pkg::REG_MAX_WIDTH: r_max_width <= pwdata[uer_pkg::CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (w_index)
            uer_pkg::REG_TIMEOUT:   prdata = uer_pkg::DATA_W'(r_timeout);
            uer_pkg::REG_MIN_WIDTH: prdata = uer_pkg::DATA_W'(r_min_width);
            uer_pkg::REG_MAX_WIDTH: prdata = uer_pkg::DATA_W'(r_max_width);
            default:                prdata = '0;
        endcase
    end

    // zero selects the default
    assign o_cfg.timeout   = (r_timeout == '0) ? uer_pkg::TIMEOUT_DEF : r_timeout;
    assign o_cfg.min_width = (r_min_width == '0) ? uer_pkg::MIN_WIDTH_DEF : r_min_width;
    assign o_cfg.max_width = (r_max_width == '0) ? uer_pkg::MAX_WIDTH_DEF : r_max_width;

endmodule

FILE: src/uer_seq.sv
module uer_seq #(
    parameter int TRIG_LOW_TICKS  = uer_pkg::TRIG_LOW_TICKS_DEF,
    parameter int TRIG_HIGH_TICKS = uer_pkg::TRIG_HIGH_TICKS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic              i_operation,
    input  logic              i_echo_level,
    input  uer_pkg::t_cfg     i_cfg,
    output uer_pkg::t_result  o_res
);

    localparam logic [uer_pkg::CNT_W-1:0] LOW_LAST  = uer_pkg::CNT_W'(TRIG_LOW_TICKS);
    localparam logic [uer_pkg::CNT_W-1:0] HIGH_LAST = uer_pkg::CNT_W'(TRIG_HIGH_TICKS);

    uer_pkg::t_phase              r_phase, n_phase;
    logic [uer_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic [uer_pkg::REM_W-1:0]    r_rem, n_rem;
    logic [uer_pkg::MM_W-1:0]     r_mm, n_mm;
    logic [uer_pkg::CMREM_W-1:0]  r_cmrem, n_cmrem;
    logic [uer_pkg::CM_W-1:0]     r_cm, n_cm;
    logic [uer_pkg::WIDTH_W-1:0]  r_held_width, n_held_width;
    logic [uer_pkg::MM_W-1:0]     r_held_mm, n_held_mm;
    logic [uer_pkg::CM_W-1:0]     r_held_cm, n_held_cm;
    logic                         r_held_valid, n_held_valid;
    uer_pkg::t_status             r_last_status, n_last_status;
    logic                         w_done;
    logic [uer_pkg::CNT_W:0]      w_cnt_inc;
    logic [uer_pkg::REM_W:0]      w_rem_sum;

    assign w_cnt_inc = {1'b0, r_cnt} + 1'b1;
    assign w_rem_sum = {1'b0, r_rem} + uer_pkg::SOUND_NUM;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= uer_pkg::PH_IDLE;
            r_cnt         <= '0;
            r_rem         <= '0;
            r_mm          <= '0;
            r_cmrem       <= '0;
            r_cm          <= '0;
            r_held_width  <= '0;
            r_held_mm     <= '0;
            r_held_cm     <= '0;
            r_held_valid  <= 1'b0;
            r_last_status <= uer_pkg::ST_OK;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_cnt         <= n_cnt;
            r_rem         <= n_rem;
            r_mm          <= n_mm;
            r_cmrem       <= n_cmrem;
            r_cm          <= n_cm;
            r_held_width  <= n_held_width;
            r_held_mm     <= n_held_mm;
            r_held_cm     <= n_held_cm;
            r_held_valid  <= n_held_valid;
            r_last_status <= n_last_status;
        end
    end

    // next state; distance tracks the running width one tick at a time
    always_comb begin
        n_phase       = r_phase;
        n_cnt         = r_cnt;
        n_rem         = r_rem;
        n_mm          = r_mm;
        n_cmrem       = r_cmrem;
        n_cm          = r_cm;
        n_held_width  = r_held_width;
        n_held_mm     = r_held_mm;
        n_held_cm     = r_held_cm;
        n_held_valid  = r_held_valid;
        n_last_status = r_last_status;
        w_done        = 1'b0;
        if (i_operation) begin
            // start request, ignored while a sequence runs
            if (r_phase == uer_pkg::PH_IDLE) begin
                n_held_width  = '0;
                n_held_mm     = '0;
                n_held_cm     = '0;
                n_held_valid  = 1'b0;
                n_last_status = uer_pkg::ST_OK;
                n_cnt         = '0;
                n_phase       = uer_pkg::PH_TRIG_LOW;
            end
        end else begin
            unique case (r_phase)
                uer_pkg::PH_IDLE: begin
                end
                uer_pkg::PH_TRIG_LOW: begin
                    n_cnt = w_cnt_inc[uer_pkg::CNT_W-1:0];
                    if (w_cnt_inc >= {1'b0, LOW_LAST}) begin
                        n_cnt   = '0;
                        n_phase = uer_pkg::PH_TRIG_HIGH;
                    end
                end
                uer_pkg::PH_TRIG_HIGH: begin
                    n_cnt = w_cnt_inc[uer_pkg::CNT_W-1:0];
                    if (w_cnt_inc >= {1'b0, HIGH_LAST}) begin
                        n_cnt   = '0;
                        n_phase = uer_pkg::PH_WAIT_RISE;
                    end
                end
                uer_pkg::PH_WAIT_RISE: begin
                    if (i_echo_level) begin
                        // first high tick: numerator is one step plus rounding
                        n_cnt   = uer_pkg::CNT_W'(1);
                        n_rem   = uer_pkg::REM_W'(uer_pkg::SOUND_NUM) + uer_pkg::ROUND_OFS;
                        n_mm    = '0;
                        n_cmrem = '0;
                        n_cm    = '0;
                        n_phase = uer_pkg::PH_MEASURE;
                        if (i_cfg.timeout == uer_pkg::CFG_W'(1)) begin
                            n_cnt         = '0;
                            n_phase       = uer_pkg::PH_IDLE;
                            n_last_status = uer_pkg::ST_NO_FALL;
                            w_done        = 1'b1;
                        end
                    end else begin
                        n_cnt = w_cnt_inc[uer_pkg::CNT_W-1:0];
                        if (w_cnt_inc >= {1'b0, i_cfg.timeout}) begin
                            n_cnt         = '0;
                            n_phase       = uer_pkg::PH_IDLE;
                            n_last_status = uer_pkg::ST_NO_RISE;
                            w_done        = 1'b1;
                        end
                    end
                end
                uer_pkg::PH_MEASURE: begin
                    if (!i_echo_level) begin
                        // echo fell: judge the width
                        n_cnt   = '0;
                        n_phase = uer_pkg::PH_IDLE;
                        w_done  = 1'b1;
                        if (r_cnt < i_cfg.min_width) begin
                            n_last_status = uer_pkg::ST_TOO_SHORT;
                        end else if (r_cnt > i_cfg.max_width) begin
                            n_last_status = uer_pkg::ST_TOO_LONG;
                        end else begin
                            n_last_status = uer_pkg::ST_OK;
                            n_held_width  = r_cnt;
                            n_held_mm     = r_mm;
                            n_held_cm     = r_cm;
                            n_held_valid  = 1'b1;
                        end
                    end else begin
                        n_cnt = w_cnt_inc[uer_pkg::CNT_W-1:0];
                        if (w_rem_sum >= uer_pkg::SOUND_DEN) begin
                            n_rem = uer_pkg::REM_W'(w_rem_sum - uer_pkg::SOUND_DEN);
                            n_mm  = r_mm + 1'b1;
                            if (r_cmrem == uer_pkg::CM_DIV_LAST) begin
                                n_cmrem = '0;
                                n_cm    = r_cm + 1'b1;
                            end else begin
                                n_cmrem = r_cmrem + 1'b1;
                            end
                        end else begin
                            n_rem = w_rem_sum[uer_pkg::REM_W-1:0];
                        end
                        if (w_cnt_inc >= {1'b0, i_cfg.timeout}) begin
                            n_cnt         = '0;
                            n_phase       = uer_pkg::PH_IDLE;
                            n_last_status = uer_pkg::ST_NO_FALL;
                            w_done        = 1'b1;
                        end
                    end
                end
                default: begin
                    n_phase = uer_pkg::PH_IDLE;
                    n_cnt   = '0;
                end
            endcase
        end
    end

    // result fields from the state after this item
    always_comb begin
        o_res.trig_level   = (n_phase == uer_pkg::PH_TRIG_HIGH);
        o_res.busy_res     = (n_phase != uer_pkg::PH_IDLE);
        o_res.done_res     = w_done;
        o_res.status       = (n_phase == uer_pkg::PH_IDLE) ? n_last_status : uer_pkg::ST_OK;
        o_res.echo_width   = n_held_width;
        o_res.dist_mm      = n_held_mm;
        o_res.distance_cm  = n_held_cm;
        o_res.result_valid = n_held_valid;
    end

endmodule

FILE: src/ultrasonic_echo_ranger_core.sv
// a request is held in the input register; its result is captured in the result register
// throughput: one request per cycle while the result register is not stalled
// the result register stalls only while a shown result is not taken
// reset: synchronous, active low; sequencer idle, held result cleared,
// limits back to 30000 / 100 / 25000 ticks
module ultrasonic_echo_ranger_core #(
    parameter int TRIG_LOW_TICKS  = uer_pkg::TRIG_LOW_TICKS_DEF,
    parameter int TRIG_HIGH_TICKS = uer_pkg::TRIG_HIGH_TICKS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_operation,
    input  logic                        i_echo_level,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_trig_level,
    output logic                        o_busy_res,
    output logic                        o_done_res,
    output logic [2:0]                  o_status,
    output logic [uer_pkg::WIDTH_W-1:0] o_echo_width,
    output logic [uer_pkg::MM_W-1:0]    o_dist_mm,
    output logic [uer_pkg::CM_W-1:0]    o_distance_cm,
    output logic                        o_result_valid,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [uer_pkg::ADDR_W-1:0]  paddr,
    input  logic [uer_pkg::DATA_W-1:0]  pwdata,
    output logic [uer_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    logic              r_in_valid;
    logic              r_in_op;
    logic              r_in_echo;
    logic              r_out_valid;
    uer_pkg::t_result  r_out;
    uer_pkg::t_result  w_res;
    uer_pkg::t_cfg     w_cfg;
    logic              w_adv;

    // stage advances when it holds a request and the result register is free or being emptied
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in_op   <= i_operation;
            r_in_echo <= i_echo_level;
        end
    end

    uer_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    uer_seq #(
        .TRIG_LOW_TICKS  (TRIG_LOW_TICKS),
        .TRIG_HIGH_TICKS (TRIG_HIGH_TICKS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_adv),
        .i_operation  (r_in_op),
        .i_echo_level (r_in_echo),
        .i_cfg        (w_cfg),
        .o_res        (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_trig_level   = r_out.trig_level;
    assign o_busy_res     = r_out.busy_res;
    assign o_done_res     = r_out.done_res;
    assign o_status       = r_out.status;
    assign o_echo_width   = r_out.echo_width;
    assign o_dist_mm      = r_out.dist_mm;
    assign o_distance_cm  = r_out.distance_cm;
    assign o_result_valid = r_out.result_valid;

endmodule

FILE: src/uer_checker.sv
`include "assert_macros.svh"

module uer_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  logic                        o_trig_level,
    input  logic                        o_busy_res,
    input  logic                        o_done_res,
    input  logic [2:0]                  o_status,
    input  logic [uer_pkg::WIDTH_W-1:0] o_echo_width,
    input  logic [uer_pkg::MM_W-1:0]    o_dist_mm,
    input  logic                        o_result_valid
);

    // a stalled result keeps its width
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_echo_width))

    // a finishing request leaves the sequencer idle
    `ASSERT_CLK(a_done_idle, i_clk, i_rst_n, o_out_valid && o_done_res |-> !o_busy_res)

    // trigger only rises inside a sequence
    `ASSERT_CLK(a_trig_busy, i_clk, i_rst_n, o_out_valid && o_trig_level |-> o_busy_res)

    // a held result means an idle, successful measurement
    `ASSERT_CLK(a_valid_ok, i_clk, i_rst_n, o_out_valid && o_result_valid |-> !o_busy_res && o_status == uer_pkg::ST_OK)

    // no width or distance without a valid result
    `ASSERT_CLK(a_zero_invalid, i_clk, i_rst_n, o_out_valid && !o_result_valid |-> o_echo_width == '0 && o_dist_mm == '0)

endmodule

bind ultrasonic_echo_ranger_core uer_checker u_uer_checker (.*);

FILE: verif/uer_ranging_checker.sv
`timescale 1ns / 1ps

module uer_ranging_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic                        i_operation,
    input  logic                        i_echo_level,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic                        i_trig_level,
    input  logic                        i_busy_res,
    input  logic                        i_done_res,
    input  logic [2:0]                  i_status,
    input  logic [uer_pkg::WIDTH_W-1:0] i_echo_width,
    input  logic [uer_pkg::MM_W-1:0]    i_dist_mm,
    input  logic [uer_pkg::CM_W-1:0]    i_distance_cm,
    input  logic                        i_result_valid,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic                        i_pready,
    input  logic [uer_pkg::ADDR_W-1:0]  i_paddr,
    input  logic [uer_pkg::DATA_W-1:0]  i_pwdata,
    output int                          o_errors,
    output int                          o_pending,
    output logic                        o_seq_idle
);

    localparam int REPORT_LIMIT = 10;

    // limits as last written, zero meaning default
    logic [uer_pkg::CFG_W-1:0]   lim_timeout;
    logic [uer_pkg::CFG_W-1:0]   lim_min;
    logic [uer_pkg::CFG_W-1:0]   lim_max;

    // predicted sequencer and held reading
    uer_pkg::t_phase             seq_phase;
    int                          seq_ticks;
    logic [uer_pkg::WIDTH_W-1:0] kept_width;
    logic [uer_pkg::MM_W-1:0]    kept_mm;
    logic                        kept_ok;
    uer_pkg::t_status            kept_status;

    uer_pkg::t_result            expected_readings[$];
    int                          mismatches;

    function automatic int eff_limit(input logic [uer_pkg::CFG_W-1:0] v,
                                     input logic [uer_pkg::CFG_W-1:0] dflt);
        return (v == '0) ? int'(dflt) : int'(v);
    endfunction

    // close the sequence, latch distance on success
    function automatic void end_seq(input uer_pkg::t_status st, input int width);
        kept_status = st;
        seq_phase   = uer_pkg::PH_IDLE;
        seq_ticks   = 0;
        if (st == uer_pkg::ST_OK) begin
            kept_width = width[uer_pkg::WIDTH_W-1:0];
            kept_mm    = uer_pkg::MM_W'((width * int'(uer_pkg::SOUND_NUM)
                                         + int'(uer_pkg::ROUND_OFS))
                                        / int'(uer_pkg::SOUND_DEN));
            kept_ok    = 1'b1;
        end
    endfunction

    // one request in, one reading out
    function automatic uer_pkg::t_result advance_ranging(input logic start, input logic echo);
        int               tmo;
        logic             done;
        uer_pkg::t_result r;
        tmo  = eff_limit(lim_timeout, uer_pkg::TIMEOUT_DEF);
        done = 1'b0;
        if (start) begin
            // start while busy is dropped
            if (seq_phase == uer_pkg::PH_IDLE) begin
                kept_width  = '0;
                kept_mm     = '0;
                kept_ok     = 1'b0;
                kept_status = uer_pkg::ST_OK;
                seq_ticks   = 0;
                seq_phase   = uer_pkg::PH_TRIG_LOW;
            end
        end else begin
            case (seq_phase)
                uer_pkg::PH_TRIG_LOW: begin
                    seq_ticks++;
                    if (seq_ticks >= uer_pkg::TRIG_LOW_TICKS_DEF) begin
                        seq_ticks = 0;
                        seq_phase = uer_pkg::PH_TRIG_HIGH;
                    end
                end
                uer_pkg::PH_TRIG_HIGH: begin
                    seq_ticks++;
                    if (seq_ticks >= uer_pkg::TRIG_HIGH_TICKS_DEF) begin
                        seq_ticks = 0;
                        seq_phase = uer_pkg::PH_WAIT_RISE;
                    end
                end
                uer_pkg::PH_WAIT_RISE: begin
                    if (echo) begin
                        // rising tick is the first counted high tick
                        seq_ticks = 1;
                        seq_phase = uer_pkg::PH_MEASURE;
                        if (seq_ticks >= tmo) begin
                            end_seq(uer_pkg::ST_NO_FALL, 0);
                            done = 1'b1;
                        end
                    end else begin
                        seq_ticks++;
                        if (seq_ticks >= tmo) begin
                            end_seq(uer_pkg::ST_NO_RISE, 0);
                            done = 1'b1;
                        end
                    end
                end
                uer_pkg::PH_MEASURE: begin
                    if (!echo) begin
                        // too short wins over too long
                        if (seq_ticks < eff_limit(lim_min, uer_pkg::MIN_WIDTH_DEF))
                            end_seq(uer_pkg::ST_TOO_SHORT, 0);
                        else if (seq_ticks > eff_limit(lim_max, uer_pkg::MAX_WIDTH_DEF))
                            end_seq(uer_pkg::ST_TOO_LONG, 0);
                        else
                            end_seq(uer_pkg::ST_OK, seq_ticks);
                        done = 1'b1;
                    end else begin
                        seq_ticks++;
                        if (seq_ticks >= tmo) begin
                            end_seq(uer_pkg::ST_NO_FALL, 0);
                            done = 1'b1;
                        end
                    end
                end
                default: begin
                    seq_phase = uer_pkg::PH_IDLE;
                    seq_ticks = 0;
                end
            endcase
        end
        r.trig_level   = (seq_phase == uer_pkg::PH_TRIG_HIGH);
        r.busy_res     = (seq_phase != uer_pkg::PH_IDLE);
        r.done_res     = done;
        r.status       = (seq_phase == uer_pkg::PH_IDLE) ? kept_status : uer_pkg::ST_OK;
        r.echo_width   = kept_ok ? kept_width : '0;
        r.dist_mm      = kept_ok ? kept_mm : '0;
        r.distance_cm  = kept_ok ? uer_pkg::CM_W'(kept_mm / 10) : '0;
        r.result_valid = kept_ok;
        return r;
    endfunction

    // watch register writes, requests and readings
    always @(posedge i_clk) begin
        uer_pkg::t_result got;
        uer_pkg::t_result want;
        if (!i_rst_n) begin
            lim_timeout = uer_pkg::TIMEOUT_DEF;
            lim_min     = uer_pkg::MIN_WIDTH_DEF;
            lim_max     = uer_pkg::MAX_WIDTH_DEF;
            seq_phase   = uer_pkg::PH_IDLE;
            seq_ticks   = 0;
            kept_width  = '0;
            kept_mm     = '0;
            kept_ok     = 1'b0;
            kept_status = uer_pkg::ST_OK;
            expected_readings.delete();
            mismatches  = 0;
        end else begin
            // register write lands at the access edge
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[uer_pkg::ADDR_W-1:2])
                    uer_pkg::REG_TIMEOUT:   lim_timeout = i_pwdata[uer_pkg::CFG_W-1:0];
                    uer_pkg::REG_MIN_WIDTH: lim_min     = i_pwdata[uer_pkg::CFG_W-1:0];
                    uer_pkg::REG_MAX_WIDTH: lim_max     = i_pwdata[uer_pkg::CFG_W-1:0];
                    default: ;
                endcase
            end
            // compare a taken reading with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                got.trig_level   = i_trig_level;
                got.busy_res     = i_busy_res;
                got.done_res     = i_done_res;
                got.status       = i_status;
                got.echo_width   = i_echo_width;
                got.dist_mm      = i_dist_mm;
                got.distance_cm  = i_distance_cm;
                got.result_valid = i_result_valid;
                if (expected_readings.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display({"%0t unexpected reading: trig=%0d busy=%0d done=%0d",
                                  " st=%0d w=%0d mm=%0d cm=%0d ok=%0d"},
                                 $realtime, got.trig_level, got.busy_res, got.done_res,
                                 got.status, got.echo_width, got.dist_mm,
                                 got.distance_cm, got.result_valid);
                end else begin
                    want = expected_readings.pop_front();
                    if (got.trig_level !== want.trig_level || got.busy_res !== want.busy_res
                        || got.done_res !== want.done_res || got.status !== want.status
                        || got.echo_width !== want.echo_width
                        || got.dist_mm !== want.dist_mm
                        || got.distance_cm !== want.distance_cm
                        || got.result_valid !== want.result_valid) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("%0t reading mismatch", $realtime);
                            $display({"  want trig=%0d busy=%0d done=%0d st=%0d",
                                      " w=%0d mm=%0d cm=%0d ok=%0d"},
                                     want.trig_level, want.busy_res, want.done_res, want.status,
                                     want.echo_width, want.dist_mm, want.distance_cm,
                                     want.result_valid);
                            $display({"  got  trig=%0d busy=%0d done=%0d st=%0d",
                                      " w=%0d mm=%0d cm=%0d ok=%0d"},
                                     got.trig_level, got.busy_res, got.done_res, got.status,
                                     got.echo_width, got.dist_mm, got.distance_cm,
                                     got.result_valid);
                        end
                    end
                end
            end
            // predict for a taken request
            if (i_in_valid && i_in_ready)
                expected_readings.push_back(advance_ranging(i_operation, i_echo_level));
        end
        o_errors   <= mismatches;
        o_pending  <= expected_readings.size();
        o_seq_idle <= (seq_phase == uer_pkg::PH_IDLE);
    end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int   CLK_PERIOD  = 20;
    localparam int   ITEM_TARGET = 850;
    localparam int   TRIG_TICKS  = uer_pkg::TRIG_LOW_TICKS_DEF + uer_pkg::TRIG_HIGH_TICKS_DEF;
    localparam int   LEN_CAP     = 120;
    localparam int   HOLD_CYCLES = 100;
    localparam int   STALL_LIMIT = 3000;
    localparam logic OP_TICK     = 1'b0;
    localparam logic OP_START    = 1'b1;

    logic                         i_clk        = 1'b0;
    logic                         i_rst_n      = 1'b0;
    logic                         i_in_valid   = 1'b0;
    logic                         i_operation  = 1'b0;
    logic                         i_echo_level = 1'b0;
    logic                         i_out_ready  = 1'b0;
    logic                         psel         = 1'b0;
    logic                         penable      = 1'b0;
    logic                         pwrite       = 1'b0;
    logic [uer_pkg::ADDR_W-1:0]   paddr        = '0;
    logic [uer_pkg::DATA_W-1:0]   pwdata       = '0;

    logic                         o_in_ready;
    logic                         o_out_valid;
    logic                         o_trig_level;
    logic                         o_busy_res;
    logic                         o_done_res;
    logic [2:0]                   o_status;
    logic [uer_pkg::WIDTH_W-1:0]  o_echo_width;
    logic [uer_pkg::MM_W-1:0]     o_dist_mm;
    logic [uer_pkg::CM_W-1:0]     o_distance_cm;
    logic                         o_result_valid;
    logic [uer_pkg::DATA_W-1:0]   prdata;
    logic                         pready;

    int                  ranging_errors;
    int                  readings_pending;
    logic                seq_idle;

    int                  send_idle_pct = 35;
    int                  recv_idle_pct = 57;
    int                  requests_sent = 0;
    bit                  long_hold     = 1'b0;
    bit                  hold_taken    = 1'b0;
    int                  hold_left     = 0;
    int                  stall_cycles  = 0;
    int                  eff_tmo;
    int                  eff_min;
    int                  eff_max;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    ultrasonic_echo_ranger_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_echo_level   (i_echo_level),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_trig_level   (o_trig_level),
        .o_busy_res     (o_busy_res),
        .o_done_res     (o_done_res),
        .o_status       (o_status),
        .o_echo_width   (o_echo_width),
        .o_dist_mm      (o_dist_mm),
        .o_distance_cm  (o_distance_cm),
        .o_result_valid (o_result_valid),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    uer_ranging_checker ranging_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_echo_level   (i_echo_level),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_trig_level   (o_trig_level),
        .i_busy_res     (o_busy_res),
        .i_done_res     (o_done_res),
        .i_status       (o_status),
        .i_echo_width   (o_echo_width),
        .i_dist_mm      (o_dist_mm),
        .i_distance_cm  (o_distance_cm),
        .i_result_valid (o_result_valid),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_errors       (ranging_errors),
        .o_pending      (readings_pending),
        .o_seq_idle     (seq_idle)
    );

    // reading side: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (long_hold && !hold_taken) begin
            hold_taken  <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // offer one request, hold it until taken
    task automatic send_request(input logic op, input logic echo);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_echo_level <= echo;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        requests_sent++;
    endtask

    task automatic stop_sending();
        i_in_valid <= 1'b0;
    endtask

    // wait for all readings, push the sequencer back to idle if needed
    task automatic settle();
        stop_sending();
        @(posedge i_clk);
        while (readings_pending != 0 || !seq_idle) begin
            if (readings_pending == 0) begin
                send_request(OP_TICK, 1'b1);
                send_request(OP_TICK, 1'b0);
                stop_sending();
            end
            @(posedge i_clk);
        end
        repeat (2) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input int val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= uer_pkg::DATA_W'(val[uer_pkg::CFG_W-1:0]);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_limits(input int tmo, input int lo, input int hi);
        apb_write(uer_pkg::REG_TIMEOUT, tmo);
        apb_write(uer_pkg::REG_MIN_WIDTH, lo);
        apb_write(uer_pkg::REG_MAX_WIDTH, hi);
        eff_tmo = (tmo == 0) ? int'(uer_pkg::TIMEOUT_DEF) : tmo;
        eff_min = (lo == 0) ? int'(uer_pkg::MIN_WIDTH_DEF) : lo;
        eff_max = (hi == 0) ? int'(uer_pkg::MAX_WIDTH_DEF) : hi;
    endtask

    // boundary lengths only where cheap, else a short random one
    function automatic int fit_len(input int v);
        if (v < 1 || v > LEN_CAP)
            return $urandom_range(1, 12);
        return v;
    endfunction

    // stimulus and verdict
    initial begin
        int k;
        int i;
        int tmo_val;
        int min_val;
        int max_val;
        int wait_len;
        int high_len;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle ticks at reset limits show the cleared reading
        send_request(OP_TICK, 1'b0);
        send_request(OP_TICK, 1'b1);
        settle();
        write_limits(3, 2, 3);

        // start, start while busy, echo toggling during trigger, shortest valid pulse
        send_request(OP_START, 1'b0);
        send_request(OP_START, 1'b1);
        for (i = 0; i < TRIG_TICKS; i++)
            send_request(OP_TICK, i[0]);
        send_request(OP_TICK, 1'b1);
        send_request(OP_TICK, 1'b1);
        send_request(OP_TICK, 1'b0);

        k = 0;
        while (requests_sent < ITEM_TARGET) begin
            if (requests_sent < ITEM_TARGET / 3) begin
                send_idle_pct = 35;
                recv_idle_pct = 57;
            end else if (requests_sent < 2 * ITEM_TARGET / 3) begin
                send_idle_pct = 57;
                recv_idle_pct = 35;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            settle();

            // limit sets: typical, smallest, largest, defaults, crossed bounds, mixes
            case (k)
                0: begin tmo_val = 40;    min_val = 3;     max_val = 20;    end
                1: begin tmo_val = 1;     min_val = 1;     max_val = 1;     end
                2: begin tmo_val = 65535; min_val = 65535; max_val = 65535; end
                3: begin tmo_val = 0;     min_val = 0;     max_val = 0;     end
                4: begin tmo_val = 12;    min_val = 10;    max_val = 5;     end
                5: begin tmo_val = 2;     min_val = 1;     max_val = 65535; end
                6: begin tmo_val = 25;    min_val = 0;     max_val = 60;    end
                default: begin
                    tmo_val = $urandom_range(1, 50);
                    min_val = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 20);
                    max_val = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 40);
                end
            endcase
            write_limits(tmo_val, min_val, max_val);
            if (send_idle_pct == 0)
                long_hold = 1'b1;

            repeat ($urandom_range(3, 5)) begin
                // well-formed measurement with random timing
                send_request(OP_START, 1'($urandom_range(0, 1)));
                for (i = 0; i < TRIG_TICKS; i++) begin
                    if ($urandom_range(0, 9) == 0)
                        send_request(OP_START, 1'($urandom_range(0, 1)));
                    send_request(OP_TICK, 1'($urandom_range(0, 1)));
                end
                case ($urandom_range(0, 4))
                    0: wait_len = fit_len(eff_tmo - 1);
                    1: wait_len = fit_len(eff_tmo);
                    default: wait_len = $urandom_range(0, 4);
                endcase
                case ($urandom_range(0, 6))
                    0: high_len = fit_len(eff_min - 1);
                    1: high_len = fit_len(eff_min);
                    2: high_len = fit_len(eff_max);
                    3: high_len = fit_len(eff_max + 1);
                    4: high_len = fit_len(eff_tmo - 1);
                    5: high_len = fit_len(eff_tmo);
                    default: high_len = $urandom_range(1, 12);
                endcase
                repeat (wait_len) send_request(OP_TICK, 1'b0);
                repeat (high_len) send_request(OP_TICK, 1'b1);
                send_request(OP_TICK, 1'b0);
                repeat ($urandom_range(0, 2))
                    send_request(OP_TICK, 1'($urandom_range(0, 1)));

                // occasional noise, may start or abandon sequences
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(1, 15))
                        send_request(($urandom_range(0, 9) == 0) ? OP_START : OP_TICK,
                                     1'($urandom_range(0, 1)));
                end
            end
            k++;
        end

        // drain and let the pipeline empty
        stop_sending();
        @(posedge i_clk);
        while (readings_pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (ranging_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
